/* src/fdl_pkg.sv */
// Shared constants and types for the fractional delay line.
`default_nettype none

package fdl_pkg;

    // Default sizes
    localparam int MAX_DEPTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field and register widths
    localparam int DELAY_BITS = 28;
    localparam int LEN_BITS   = 13;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 13'd4096;

    // Request kinds carried on tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_LENGTH = 1'b0;

    // Memory port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage : fdl_pkg

`default_nettype wire

/* src/fdl_store.sv */
// Sample memory: one write port, two registered read ports.
`default_nettype none

module fdl_store #(
    parameter int MAX_DEPTH   = fdl_pkg::MAX_DEPTH_DEF,
    parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
    parameter int AW          = $clog2(MAX_DEPTH)
) (
    input  wire                        aclk,
    input  wire fdl_pkg::mem_ctl_t     ctl,
    input  wire  [AW-1:0]              wr_addr,
    input  wire  [SAMPLE_BITS-1:0]     wr_data,
    input  wire  [AW-1:0]              rd_addr0,
    input  wire  [AW-1:0]              rd_addr1,
    output logic [SAMPLE_BITS-1:0]     rd_data0,
    output logic [SAMPLE_BITS-1:0]     rd_data1
);

    logic [SAMPLE_BITS-1:0] mem [MAX_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read request
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule : fdl_store

`default_nettype wire

/* src/fdl_ctrl.sv */
// Length register, write pointer, clearing sweep and read address generation.
`default_nettype none

module fdl_ctrl #(
    parameter int MAX_DEPTH   = fdl_pkg::MAX_DEPTH_DEF,
    parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF,
    parameter int AW          = $clog2(MAX_DEPTH)
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [fdl_pkg::PADDR_BITS-1:0]    paddr,
    input  wire  [fdl_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [fdl_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    // request side
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire                               op,
    input  wire  [SAMPLE_BITS-1:0]            sample_in,
    input  wire  [fdl_pkg::DELAY_BITS-1:0]    delay,
    input  wire                               issue_ready,
    // memory and datapath
    output fdl_pkg::mem_ctl_t                 mem_ctl,
    output logic [AW-1:0]                     wr_addr,
    output logic [SAMPLE_BITS-1:0]            wr_data,
    output logic [AW-1:0]                     rd_addr0,
    output logic [AW-1:0]                     rd_addr1,
    output logic [FRAC_BITS-1:0]              rd_frac,
    output logic                              rd_clamped
);

    localparam int LW = AW + 1;
    localparam int IW = fdl_pkg::DELAY_BITS - FRAC_BITS;
    localparam int CW = ((IW > LW) ? IW : LW) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DEPTH - 1);

    function automatic logic [LW-1:0] eff_len(input logic [fdl_pkg::LEN_BITS-1:0] raw);
        logic [LW-1:0] r;
        if (raw == '0) begin
            r = LW'(1);
        end else if (32'(raw) > 32'(MAX_DEPTH)) begin
            r = LW'(MAX_DEPTH);
        end else begin
            r = LW'(raw);
        end
        return r;
    endfunction

    logic [fdl_pkg::LEN_BITS-1:0] len_raw_reg, len_raw_next;
    logic [LW-1:0]                len_reg,     len_next;
    logic [AW-1:0]                wp_reg,      wp_next;
    logic                         clr_reg,     clr_next;
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;

    logic           cfg_wr;
    logic           accept;
    logic           push;
    logic [IW-1:0]  ip;
    logic           clamp;
    logic [LW-1:0]  ipc;
    logic [LW-1:0]  pos;
    logic [LW-1:0]  i0;
    logic [LW-1:0]  i0_inc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == fdl_pkg::REG_LENGTH);
    assign prdata = (paddr[2] == fdl_pkg::REG_LENGTH) ? fdl_pkg::PDATA_BITS'(len_raw_reg) : '0;

    assign s_tready = !clr_reg && issue_ready;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (op == fdl_pkg::OP_PUSH);

    // Read position: write pointer + integer delay + 1, wrapped once
    assign ip    = delay[fdl_pkg::DELAY_BITS-1:FRAC_BITS];
    assign clamp = CW'(ip) >= CW'(len_reg);
    assign ipc   = clamp ? (len_reg - LW'(1)) : LW'(ip);
    assign pos   = LW'(wp_reg) + ipc + LW'(1);
    assign i0    = (pos >= len_reg) ? (pos - len_reg) : pos;
    assign i0_inc = i0 + LW'(1);

    assign rd_addr0   = i0[AW-1:0];
    assign rd_addr1   = (i0_inc == len_reg) ? '0 : i0_inc[AW-1:0];
    assign rd_frac    = clamp ? '0 : delay[FRAC_BITS-1:0];
    assign rd_clamped = clamp;

    assign mem_ctl.rd_en = accept && (op == fdl_pkg::OP_READ);
    assign mem_ctl.wr_en = clr_reg || push;
    assign wr_addr       = clr_reg ? clr_addr_reg : wp_reg;
    assign wr_data       = clr_reg ? '0 : sample_in;

    always_comb begin
        len_raw_next  = len_raw_reg;
        len_next      = len_reg;
        wp_next       = wp_reg;
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR) begin
                clr_next = 1'b0;
            end
        end
        if (push) begin
            // step down, wrap from zero to the top of the line
            wp_next = (wp_reg == '0) ? AW'(len_reg - LW'(1)) : (wp_reg - AW'(1));
        end
        if (cfg_wr) begin
            len_raw_next = pwdata[fdl_pkg::LEN_BITS-1:0];
            len_next     = eff_len(pwdata[fdl_pkg::LEN_BITS-1:0]);
            wp_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_raw_reg  <= fdl_pkg::LEN_RESET;
            len_reg      <= eff_len(fdl_pkg::LEN_RESET);
            wp_reg       <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            len_raw_reg  <= len_raw_next;
            len_reg      <= len_next;
            wp_reg       <= wp_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

endmodule : fdl_ctrl

`default_nettype wire

/* src/fdl_interp.sv */
// Interpolation pipeline: read data stage, product stage, output register.
`default_nettype none

module fdl_interp #(
    parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          issue,
    input  wire  [FRAC_BITS-1:0]         issue_frac,
    input  wire                          issue_clamped,
    output logic                         issue_ready,
    input  wire  [SAMPLE_BITS-1:0]       rd_data0,
    input  wire  [SAMPLE_BITS-1:0]       rd_data1,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [SAMPLE_BITS-1:0]       out_sample,
    output logic                         out_clamped
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = DW + FRAC_BITS + 1;
    localparam int RW = SAMPLE_BITS + 2;

    logic                   s1_valid_reg, s1_valid_next;
    logic [FRAC_BITS-1:0]   s1_frac_reg;
    logic                   s1_clamped_reg;

    logic                   s2_valid_reg;
    logic signed [PW-1:0]   s2_prod_reg;
    logic signed [SAMPLE_BITS-1:0] s2_v0_reg;
    logic                   s2_clamped_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_clamped_reg;

    logic                   out_free;
    logic                   s2_free;
    logic signed [DW-1:0]   diff;
    logic signed [PW-1:0]   prod;
    logic signed [RW-1:0]   sum;

    // Each stage moves when the one after it is empty or moving
    assign out_free    = !out_valid_reg || out_ready;
    assign s2_free     = !s2_valid_reg || out_free;
    assign issue_ready = !s1_valid_reg || s2_free;

    assign diff = DW'($signed(rd_data1)) - DW'($signed(rd_data0));
    assign prod = PW'(diff) * $signed({1'b0, s1_frac_reg});
    // arithmetic shift gives the floor of the scaled step
    assign sum  = RW'(s2_v0_reg) + RW'(s2_prod_reg >>> FRAC_BITS);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (issue) begin
            s1_valid_next = 1'b1;
        end else if (s2_free) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_frac_reg    <= issue_frac;
            s1_clamped_reg <= issue_clamped;
        end
        if (s2_free) begin
            s2_prod_reg    <= prod;
            s2_v0_reg      <= $signed(rd_data0);
            s2_clamped_reg <= s1_clamped_reg;
        end
        if (out_free) begin
            out_sample_reg  <= sum[SAMPLE_BITS-1:0];
            out_clamped_reg <= s2_clamped_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign out_clamped = out_clamped_reg;

endmodule : fdl_interp

`default_nettype wire

/* src/fractional_delay_line.sv */
// Top level of the fractional delay line with linear interpolation.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tdata: sample_in, delay; tuser: op
//  m_*       out        m_tvalid/m_tready   tdata: sample_out; tuser: delay_clamped
//  apb       in/out     psel/penable/pready reg 0 length at byte address 0
//
// One request per cycle, push or read, while s_tready is high. A push writes
// the memory at the edge it is accepted; a read issues both memory reads at its
// accept edge, and its result passes the product and sum stages into the
// output register. After reset a clearing sweep zeroes every memory entry
// with s_tready low; configuration writes are taken during the sweep.
// While the output is stalled, up to two more reads fill the pipeline.
`default_nettype none

module fractional_delay_line #(
    parameter int MAX_DEPTH   = fdl_pkg::MAX_DEPTH_DEF,
    parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF,
    parameter int IN_W        = ((SAMPLE_BITS + fdl_pkg::DELAY_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [fdl_pkg::PADDR_BITS-1:0]   paddr,
    input  wire  [fdl_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [fdl_pkg::PDATA_BITS-1:0]   prdata,
    output logic                             pready,
    // requests
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [IN_W-1:0]                  s_tdata,  // sample_in, delay
    input  wire                              s_tuser,  // op
    // results
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [OUT_W-1:0]                 m_tdata,  // sample_out
    output logic                             m_tuser   // delay_clamped
);

    localparam int AW = $clog2(MAX_DEPTH);

    fdl_pkg::mem_ctl_t          mem_ctl;
    logic [AW-1:0]              wr_addr;
    logic [SAMPLE_BITS-1:0]     wr_data;
    logic [AW-1:0]              rd_addr0;
    logic [AW-1:0]              rd_addr1;
    logic [SAMPLE_BITS-1:0]     rd_data0;
    logic [SAMPLE_BITS-1:0]     rd_data1;
    logic [FRAC_BITS-1:0]       rd_frac;
    logic                       rd_clamped;
    logic                       issue_ready;
    logic [SAMPLE_BITS-1:0]     out_sample;

    fdl_ctrl #(
        .MAX_DEPTH   (MAX_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .AW          (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .op          (s_tuser),
        .sample_in   (s_tdata[SAMPLE_BITS-1:0]),
        .delay       (s_tdata[SAMPLE_BITS+fdl_pkg::DELAY_BITS-1:SAMPLE_BITS]),
        .issue_ready (issue_ready),
        .mem_ctl     (mem_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr0    (rd_addr0),
        .rd_addr1    (rd_addr1),
        .rd_frac     (rd_frac),
        .rd_clamped  (rd_clamped)
    );

    fdl_store #(
        .MAX_DEPTH   (MAX_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_store (
        .aclk        (aclk),
        .ctl         (mem_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr0    (rd_addr0),
        .rd_addr1    (rd_addr1),
        .rd_data0    (rd_data0),
        .rd_data1    (rd_data1)
    );

    fdl_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .issue         (mem_ctl.rd_en),
        .issue_frac    (rd_frac),
        .issue_clamped (rd_clamped),
        .issue_ready   (issue_ready),
        .rd_data0      (rd_data0),
        .rd_data1      (rd_data1),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_sample    (out_sample),
        .out_clamped   (m_tuser)
    );

    assign m_tdata = OUT_W'(out_sample);

endmodule : fractional_delay_line

`default_nettype wire

/* tb/fractional_delay_line_tb.sv */
// Self-checking testbench for the fractional delay line: pushes, interpolated reads, length changes.
`default_nettype none

module fractional_delay_line_tb;

    localparam int SW       = fdl_pkg::SAMPLE_BITS_DEF;
    localparam int FW       = fdl_pkg::FRAC_BITS_DEF;
    localparam int DEPTH    = fdl_pkg::MAX_DEPTH_DEF;
    localparam int DBITS    = fdl_pkg::DELAY_BITS;
    localparam int LBITS    = fdl_pkg::LEN_BITS;
    localparam int PDBITS   = fdl_pkg::PDATA_BITS;
    localparam int PABITS   = fdl_pkg::PADDR_BITS;
    localparam int IN_W     = ((SW + DBITS + 7) / 8) * 8;
    localparam int OUT_W    = ((SW + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int PHASE_REQS = 55;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [PABITS-1:0] LENGTH_ADDR = {fdl_pkg::REG_LENGTH, 2'b00};

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          clamped;
    } delay_result_t;

    class delay_line_scoreboard;
        logic signed [SW-1:0] line_mem [DEPTH];
        int unsigned          wr_pos;
        logic [LBITS-1:0]     len_reg;
        delay_result_t        pending_reads [$];
        int                   errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            wr_pos  = 0;
            len_reg = fdl_pkg::LEN_RESET;
            errors  = 0;
        endfunction

        function int unsigned eff_len();
            if (len_reg == 0) return 1;
            if (len_reg > DEPTH) return DEPTH;
            return 32'(len_reg);
        endfunction

        function int pending();
            return pending_reads.size();
        endfunction

        function void flag(string what, longint exp_v, longint act_v);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
        endfunction

        function void set_length(logic [PDBITS-1:0] value);
            len_reg = value[LBITS-1:0];
            wr_pos  = 0;
        endfunction

        function void check_length(logic [PDBITS-1:0] rd);
            if (rd !== {{(PDBITS-LBITS){1'b0}}, len_reg})
                flag("length readback", len_reg, rd);
        endfunction

        function void note_request(logic op, logic [SW-1:0] smp, logic [DBITS-1:0] dly);
            int unsigned   e, wp, ip, frac, i0, i1;
            longint        v0, v1, prod, res;
            delay_result_t r;
            e  = eff_len();
            wp = (wr_pos >= e) ? 0 : wr_pos;
            if (op == fdl_pkg::OP_PUSH) begin
                line_mem[wp] = smp;
                wr_pos = (wp == 0) ? e - 1 : wp - 1;
            end else begin
                ip        = 32'(dly[DBITS-1:FW]);
                frac      = 32'(dly[FW-1:0]);
                r.clamped = 1'b0;
                if (ip >= e) begin
                    ip        = e - 1;
                    frac      = 0;
                    r.clamped = 1'b1;
                end
                i0   = (wp + ip + 1) % e;
                i1   = (i0 + 1) % e;
                v0   = longint'(line_mem[i0]);
                v1   = longint'(line_mem[i1]);
                prod = (v1 - v0) * longint'(frac);
                // arithmetic shift rounds toward minus infinity
                res  = v0 + (prod >>> FW);
                r.sample = res[SW-1:0];
                pending_reads.push_back(r);
            end
        endfunction

        function void check_result(logic [SW-1:0] smp, logic clamped);
            delay_result_t r;
            if (pending_reads.size() == 0) begin
                flag("unexpected result", 0, smp);
                return;
            end
            r = pending_reads.pop_front();
            if (smp !== r.sample) flag("sample_out", r.sample, smp);
            if (clamped !== r.clamped) flag("delay_clamped", r.clamped, clamped);
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PABITS-1:0]      paddr    = '0;
    logic [PDBITS-1:0]      pwdata   = '0;
    logic [PDBITS-1:0]      prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata  = '0;   // sample_in, delay
    logic                   s_tuser  = 1'b0; // op
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;         // sample_out
    logic                   m_tuser;         // delay_clamped

    delay_line_scoreboard sb = new();
    int idle_cycles = 0;
    int ready_hold  = 0;

    fractional_delay_line DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure: mostly short stalls, some long ones, some stall-free stretches
    always @(negedge aclk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(0, 8);
            end else if (r < 90) begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else if (r < 97) begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(20, 80);
            end else begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[SW-1:0], m_tuser);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("fractional_delay_line test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [DBITS-1:0] pick_delay(int unsigned e);
        int unsigned r, ip;
        logic [FW-1:0] frac;
        r = $urandom_range(0, 99);
        if (r >= 85) return DBITS'($urandom);
        if (r < 55)      ip = $urandom_range(0, (e > 64) ? 63 : e - 1);
        else if (r < 70) ip = (e - 1) + $urandom_range(0, 1);
        else             ip = $urandom_range(0, 4095);
        if (ip > 4095) ip = 4095;
        case ($urandom_range(0, 9))
            0: frac = '0;
            1: frac = '1;
            default: frac = FW'($urandom);
        endcase
        return {ip[11:0], frac};
    endfunction

    // callers enter and leave on a falling edge
    task automatic send_request(input logic op, input logic [SW-1:0] smp,
                                input logic [DBITS-1:0] dly);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W-SW-DBITS){1'b0}}, dly, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, smp, dly);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        logic op;
        repeat (count) begin
            op = ($urandom_range(0, 1) == 0) ? fdl_pkg::OP_PUSH : fdl_pkg::OP_READ;
            send_request(op, pick_sample(), pick_delay(sb.eff_len()));
        end
    endtask

    // hold the sender until every read has returned, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_length(input logic [PDBITS-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LENGTH_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_length(value);
        @(negedge aclk);
        // read back in the same bus tenure
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.check_length(prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [PDBITS-1:0] phase_len [11];
        phase_len = '{32'd4096, 32'd16, 32'd3, 32'd1, 32'd0, 32'd8191,
                      32'd2, 32'd4097, 32'd100, 32'd4095, 32'd7};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset length: cleared store, full-scale samples, wrap of the next entry
        send_request(fdl_pkg::OP_READ, 24'h000000, 28'h0000000);
        send_request(fdl_pkg::OP_PUSH, 24'h7FFFFF, 28'h0000000);
        send_request(fdl_pkg::OP_PUSH, 24'h800000, 28'hFFFFFFF);
        send_request(fdl_pkg::OP_PUSH, 24'h000000, 28'h0000000);
        send_request(fdl_pkg::OP_PUSH, 24'hFFFFFF, 28'h5555555);
        send_request(fdl_pkg::OP_PUSH, 24'h555555, 28'hAAAAAAA);
        send_request(fdl_pkg::OP_PUSH, 24'hAAAAAA, 28'h0000000);
        send_request(fdl_pkg::OP_READ, 24'h000000, {12'd0, 16'h0000});
        send_request(fdl_pkg::OP_READ, 24'hFFFFFF, {12'd4, 16'h8000});
        send_request(fdl_pkg::OP_READ, 24'h000000, {12'd5, 16'hFFFF});
        send_request(fdl_pkg::OP_READ, 24'h000000, 28'hFFFFFFF);
        drain();

        // short line: integer delay, fraction across the wrap, clamping
        write_length(32'd4);
        send_request(fdl_pkg::OP_PUSH, 24'h123456, 28'h0000000);
        send_request(fdl_pkg::OP_PUSH, 24'hFEDCBA, 28'h0000000);
        send_request(fdl_pkg::OP_PUSH, 24'h7FFFFF, 28'h0000000);
        send_request(fdl_pkg::OP_PUSH, 24'h800000, 28'h0000000);
        send_request(fdl_pkg::OP_READ, 24'h000000, {12'd0, 16'h0000});
        send_request(fdl_pkg::OP_READ, 24'h000000, {12'd3, 16'h4000});
        send_request(fdl_pkg::OP_READ, 24'h000000, {12'd4, 16'h1234});
        send_request(fdl_pkg::OP_READ, 24'h000000, 28'hFFFFFFF);
        drain();

        // single entry: both taps hit the same sample
        write_length(32'd1);
        send_request(fdl_pkg::OP_PUSH, 24'hC00001, 28'h0000000);
        send_request(fdl_pkg::OP_READ, 24'h000000, {12'd0, 16'h8000});
        send_request(fdl_pkg::OP_READ, 24'h000000, {12'd1, 16'hFFFF});
        drain();

        foreach (phase_len[p]) begin
            write_length(phase_len[p]);
            if (p == 2) begin
                send_random(PHASE_REQS / 2);
                drain();
                send_random(PHASE_REQS - PHASE_REQS / 2);
            end else begin
                send_random(PHASE_REQS);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("fractional_delay_line test passed");
        else
            $display("fractional_delay_line test failed");
        $finish;
    end

endmodule

`default_nettype wire
